// ----- rtl/core/lpg_pkg.sv -----
// shared types and constants of the line pixel generator
package lpg_pkg;

    localparam int COORD_W = 6;
    localparam int COLOR_W = 24;

    // classified line request, coordinates held at full port width
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic               dir_neg;
        logic               steep;
        logic [COLOR_W-1:0] color;
    } lpg_cmd_t;

endpackage

// ----- rtl/core/line_pixel_generator.sv -----
// top level of the bresenham line pixel generator
//
//  channel | dir | beat content (tdata low bit first)                 | tlast
//  s_      | in  | x_start[5:0] y_start[11:6] x_end[17:12] y_end[23:18] |  -
//          |     | line_color[47:24]                                   |
//  m_      | out | pixel_x[5:0] pixel_y[11:6] pixel_color[35:12]       | last_pixel
//
//  a line of n = max(|dx|,|dy|)+1 pixels: the rasterizer first loads the command,
//  then gives one pixel per cycle from its stepping loop while the output is not held
//  the front end takes a request each cycle while the two-entry queue has room,
//  so a request can land while the previous line is still drawing
//  output beats sit in a register; m_tready low holds the current pixel and the loop
//  aresetn (synchronous, active low) empties the queue and drops m_tvalid
module line_pixel_generator import lpg_pkg::*; #(
    parameter int COORD_BITS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_start, y_start, x_end, y_end, line_color
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_x, pixel_y, pixel_color, zero pad
    output logic        m_tlast    // last_pixel
);

    lpg_cmd_t           front_cmd, head_cmd;
    logic               q_full, q_empty, q_pop, q_push;
    logic [COORD_W-1:0] pixel_x, pixel_y;
    logic [COLOR_W-1:0] pixel_color;

    // classify the incoming request combinationally
    lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
        .x_start    (s_tdata[5:0]),
        .y_start    (s_tdata[11:6]),
        .x_end      (s_tdata[17:12]),
        .y_end      (s_tdata[23:18]),
        .line_color (s_tdata[47:24]),
        .cmd        (front_cmd)
    );

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // decouples request intake from pixel stepping
    lpg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    // pixel stepping loop with registered output beat
    lpg_raster #(.COORD_BITS(COORD_BITS)) u_raster (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_empty   (q_empty),
        .cmd         (head_cmd),
        .cmd_pop     (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (m_tlast)
    );

    // pack the pixel beat, upper nibble zero
    assign m_tdata = {4'b0000, pixel_color, pixel_y, pixel_x};

endmodule

// ----- rtl/core/lpg_front.sv -----
// front end: orders endpoints by column and classifies the line
module lpg_front import lpg_pkg::*; #(
    parameter int COORD_BITS = 6
) (
    input  logic [COORD_W-1:0] x_start,
    input  logic [COORD_W-1:0] y_start,
    input  logic [COORD_W-1:0] x_end,
    input  logic [COORD_W-1:0] y_end,
    input  logic [COLOR_W-1:0] line_color,
    output lpg_cmd_t           cmd
);

    logic [COORD_BITS-1:0] xa, ya, xb, yb;
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [COORD_BITS-1:0] dx, dy;
    logic                  dir_neg;

    assign xa = x_start[COORD_BITS-1:0];
    assign ya = y_start[COORD_BITS-1:0];
    assign xb = x_end[COORD_BITS-1:0];
    assign yb = y_end[COORD_BITS-1:0];

    always_comb begin
        if (xa > xb) begin
            x0 = xb;
            y0 = yb;
            x1 = xa;
            y1 = ya;
        end else begin
            x0 = xa;
            y0 = ya;
            x1 = xb;
            y1 = yb;
        end
        dx      = x1 - x0;
        dir_neg = (y1 < y0);
        dy      = dir_neg ? (y0 - y1) : (y1 - y0);
    end

    always_comb begin
        cmd.x0      = COORD_W'(x0);
        cmd.y0      = COORD_W'(y0);
        cmd.dx      = COORD_W'(dx);
        cmd.dy      = COORD_W'(dy);
        cmd.dir_neg = dir_neg;
        cmd.steep   = (dy > dx);
        cmd.color   = line_color;
    end

endmodule

// ----- rtl/core/lpg_queue.sv -----
// two-entry command queue between front end and rasterizer
module lpg_queue import lpg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  lpg_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output lpg_cmd_t head_cmd
);

    lpg_cmd_t    entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/lpg_raster.sv -----
// back end: steps the bresenham line one pixel per beat into an output register
module lpg_raster import lpg_pkg::*; #(
    parameter int COORD_BITS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_empty,
    input  lpg_cmd_t           cmd,
    output logic               cmd_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [COORD_W-1:0] pixel_x,
    output logic [COORD_W-1:0] pixel_y,
    output logic [COLOR_W-1:0] pixel_color,
    output logic               last_pixel
);

    localparam int PW = COORD_BITS + 3;

    typedef enum logic {IDLE, RUN} state_t;

    state_t                 state_reg;
    logic [COORD_BITS-1:0]  x_reg, y_reg, cnt_reg;
    logic [COORD_BITS-1:0]  major_reg, minor_reg;
    logic signed [PW-1:0]   p_reg;
    logic                   steep_reg, dir_neg_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic                   m_tvalid_reg;
    logic [COORD_W-1:0]     pixel_x_reg, pixel_y_reg;
    logic [COLOR_W-1:0]     pixel_color_reg;
    logic                   last_pixel_reg;

    logic [COORD_BITS-1:0]  c_dx, c_dy, c_major, c_minor;
    logic signed [PW-1:0]   p_init, p_next, maj2, min2;
    logic                   p_pos, out_load, step_x, step_y;
    logic [COORD_BITS-1:0]  x_next, y_next;

    assign c_dx    = cmd.dx[COORD_BITS-1:0];
    assign c_dy    = cmd.dy[COORD_BITS-1:0];
    assign c_major = cmd.steep ? c_dy : c_dx;
    assign c_minor = cmd.steep ? c_dx : c_dy;
    assign p_init  = signed'(PW'({c_minor, 1'b0})) - signed'(PW'(c_major));

    assign cmd_pop  = (state_reg == IDLE) && !cmd_empty;
    assign out_load = (state_reg == RUN) && (!m_tvalid_reg || m_tready);

    // decision term update
    assign maj2   = signed'(PW'({major_reg, 1'b0}));
    assign min2   = signed'(PW'({minor_reg, 1'b0}));
    assign p_pos  = (p_reg >= 0);
    assign p_next = p_reg + min2 - (p_pos ? maj2 : '0);

    // major axis steps every pixel, minor axis on a nonnegative term
    assign step_x = steep_reg ? p_pos : 1'b1;
    assign step_y = steep_reg ? 1'b1 : p_pos;
    assign x_next = step_x ? (x_reg + 1'b1) : x_reg;
    assign y_next = !step_y ? y_reg : (dir_neg_reg ? (y_reg - 1'b1) : (y_reg + 1'b1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (cmd_pop) begin
                        state_reg <= RUN;
                    end
                end
                RUN: begin
                    if (out_load && (cnt_reg == '0)) begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
        if (cmd_pop) begin
            x_reg       <= cmd.x0[COORD_BITS-1:0];
            y_reg       <= cmd.y0[COORD_BITS-1:0];
            cnt_reg     <= c_major;
            major_reg   <= c_major;
            minor_reg   <= c_minor;
            p_reg       <= p_init;
            steep_reg   <= cmd.steep;
            dir_neg_reg <= cmd.dir_neg;
            color_reg   <= cmd.color;
        end else if (out_load) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            p_reg   <= p_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (out_load) begin
            pixel_x_reg     <= COORD_W'(x_reg);
            pixel_y_reg     <= COORD_W'(y_reg);
            pixel_color_reg <= color_reg;
            last_pixel_reg  <= (cnt_reg == '0);
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

    // a new command is only taken once the previous line is done
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (state_reg == IDLE))
        else $error("command popped while a line is running");

    // issuing the final pixel ends the line
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (cnt_reg == '0)) |=> (state_reg == IDLE) && last_pixel_reg)
        else $error("final pixel did not end the line");

    // decision term stays within its bresenham bounds
    a_p_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RUN) |-> ((p_reg >= -maj2) && (p_reg <= min2)))
        else $error("decision term out of range");

endmodule

// ----- test/lpg_scoreboard_pkg.sv -----
// scoreboard class that predicts and checks the pixel beats of the line generator
`timescale 1ns / 1ps

package lpg_tb_pkg;
    import lpg_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t expected_pixels[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40)
                $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        // bresenham walk over one request, pushing every pixel in drawing order
        function void trace_line(logic [47:0] beat);
            int xa, ya, xb, yb, t, dx, dy, dir, p, x, y, n, i;
            logic [COLOR_W-1:0] color;
            pixel_t px;
            xa = beat[5:0];
            ya = beat[11:6];
            xb = beat[17:12];
            yb = beat[23:18];
            color = beat[47:24];
            // order by x, a shared column keeps the start endpoint first
            if (xa > xb) begin
                t = xa; xa = xb; xb = t;
                t = ya; ya = yb; yb = t;
            end
            dx = xb - xa;
            dy = yb - ya;
            dir = (dy < 0) ? -1 : 1;
            dy = dy * dir;
            x = xa;
            y = ya;
            if (dx >= dy) begin
                n = dx + 1;
                p = 2 * dy - dx;
            end else begin
                n = dy + 1;
                p = 2 * dx - dy;
            end
            for (i = 0; i < n; i++) begin
                px.x = x[COORD_W-1:0];
                px.y = y[COORD_W-1:0];
                px.color = color;
                px.last = (i == n - 1);
                expected_pixels.push_back(px);
                if (dx >= dy) begin
                    if (p >= 0) begin
                        y += dir;
                        p -= 2 * dx;
                    end
                    p += 2 * dy;
                    x += 1;
                end else begin
                    if (p >= 0) begin
                        x += 1;
                        p -= 2 * dy;
                    end
                    p += 2 * dx;
                    y += dir;
                end
            end
        endfunction

        function void note_request(logic [47:0] beat);
            trace_line(beat);
        endfunction

        task check_pixel(logic [39:0] beat, logic last);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                                          beat[5:0], beat[11:6], beat[35:12], last));
                return;
            end
            want = expected_pixels.pop_front();
            if (beat[5:0] !== want.x)
                report_mismatch($sformatf("pixel_x got %0d want %0d", beat[5:0], want.x));
            if (beat[11:6] !== want.y)
                report_mismatch($sformatf("pixel_y got %0d want %0d", beat[11:6], want.y));
            if (beat[35:12] !== want.color)
                report_mismatch($sformatf("pixel_color got %06h want %06h",
                                          beat[35:12], want.color));
            if (last !== want.last)
                report_mismatch($sformatf("last_pixel got %0b want %0b at x=%0d y=%0d",
                                          last, want.last, want.x, want.y));
        endtask
    endclass

endpackage

// ----- test/tb_line_pixel_generator.sv -----
// testbench top for the bresenham line pixel generator
`timescale 1ns / 1ps

module tb_line_pixel_generator;
    import lpg_pkg::*;
    import lpg_tb_pkg::*;

    localparam int IDLE_PCT   = 23;   // chance per hundred that a side idles
    localparam int HOLD_CYCLES = 400; // long receiver hold-off
    localparam int TAIL_CYCLES = 80;  // settle time after the last pixel

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // x_start, y_start, x_end, y_end, line_color
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // pixel_x, pixel_y, pixel_color, zero pad
    logic        m_tlast;   // last_pixel

    pixel_scoreboard sb = new();

    // calm turns off idling on both sides, hold_request asks the sink for a hold-off
    bit calm = 1'b0;
    bit hold_request = 1'b0;

    line_pixel_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // monitors sample at the edge, before any of this edge's updates land
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tlast);
    end

    // pixel sink: random backpressure, none while calm, and a long hold-off on request
    initial begin : pixel_sink
        int held;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_request) begin
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // hold one request beat until it is taken, valid stays high on return
    task send_beat(logic [47:0] beat);
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
    endtask

    // random gap after a beat, skipped while calm
    task maybe_idle();
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task send_line(int x0, int y0, int x1, int y1, logic [COLOR_W-1:0] color);
        logic [47:0] beat;
        beat = {color, 6'(y1), 6'(x1), 6'(y0), 6'(x0)};
        send_beat(beat);
        maybe_idle();
    endtask

    // sender pauses until every pixel owed has come out
    task pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // mostly short lines near a random anchor, some spanning the whole grid
    task send_random_line();
        int x0, y0, x1, y1;
        x0 = $urandom_range(63);
        y0 = $urandom_range(63);
        if ($urandom_range(99) < 25) begin
            x1 = $urandom_range(63);
            y1 = $urandom_range(63);
        end else begin
            x1 = x0 + $urandom_range(12) - 6;
            y1 = y0 + $urandom_range(12) - 6;
            if (x1 < 0) x1 = 0;
            if (x1 > 63) x1 = 63;
            if (y1 < 0) y1 = 0;
            if (y1 > 63) y1 = 63;
        end
        send_line(x0, y0, x1, y1, COLOR_W'($urandom()));
    endtask

    initial begin : stimulus
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        aresetn  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        // directed: single points at the grid corners
        send_line(0, 0, 0, 0, 24'h000000);
        send_line(63, 63, 63, 63, 24'hffffff);
        // full-width rows, one given right to left
        send_line(0, 0, 63, 0, 24'ha5a5a5);
        send_line(63, 5, 0, 5, 24'h5a5a5a);
        // vertical columns, downward and upward, start endpoint stays first
        send_line(7, 0, 7, 63, 24'h123456);
        send_line(7, 63, 7, 0, 24'hfedcba);
        // diagonals in both directions
        send_line(0, 0, 63, 63, 24'hff0000);
        send_line(0, 63, 63, 0, 24'h00ff00);
        send_line(63, 0, 0, 63, 24'h0000ff);
        // shallow and steep slopes, each also given reversed
        send_line(10, 10, 20, 13, 24'h800001);
        send_line(20, 13, 10, 10, 24'h7ffffe);
        send_line(10, 10, 13, 40, 24'h0f0f0f);
        send_line(13, 40, 10, 10, 24'hf0f0f0);
        send_line(10, 40, 13, 10, 24'h333333);
        // near-vertical and near-horizontal spans
        send_line(0, 0, 1, 63, 24'hcccccc);
        send_line(0, 0, 63, 1, 24'h999999);
        send_line(62, 1, 63, 0, 24'h010203);
        send_line(31, 31, 32, 32, 24'hfffffe);
        send_line(32, 0, 31, 63, 24'h000001);
        pause_until_drained();

        // random lines with idling on both sides
        repeat (120) send_random_line();

        // stretch with no idling anywhere
        calm = 1'b1;
        repeat (60) send_random_line();
        calm = 1'b0;

        // receiver holds off while requests keep coming, so the input stalls
        hold_request = 1'b1;
        repeat (20) send_random_line();
        pause_until_drained();

        repeat (91) send_random_line();

        // wind down: wait out every pixel, then a quiet tail
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("line_pixel_generator test passed");
        else
            $display("line_pixel_generator test failed");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("line_pixel_generator test failed");
        $finish;
    end

endmodule
